### hdl/prpl_pkg.sv
// ----------------------------------------------------------------------------
// prpl_pkg
// Shared types and constants of the pulse rate period logger.
// ----------------------------------------------------------------------------
`default_nettype none

package prpl_pkg;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_COLLECT  = 2'd0,
    STAT_INACTIVE = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic {
    CFG_PERIOD  = 1'b0,
    CFG_MIN_GAP = 1'b1
  } cfg_index_t;

  localparam int COUNT_W = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 6;
  localparam int SLOT_W  = 7;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [CFG_W-1:0]   PERIOD_RESET  = 16'd1000;
  localparam logic [CFG_W-1:0]   MIN_GAP_RESET = 16'd100;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } slot_entry_t;

endpackage

`default_nettype wire

### hdl/pulse_rate_period_logger.sv
// ----------------------------------------------------------------------------
// pulse_rate_period_logger
// Counts debounced falling edges of a sensor pin and bins them by period.
// A request is accepted into the execute stage; its result is loaded into
// the output register as that stage fires and held while the result side stalls.
// Throughput: one request per cycle unless the result side stalls; the slot
// read is issued at accept, and the read-modify-write completes at execute, with forwarding.
// Reset: synchronous; control and valid bits clear; slot memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_rate_period_logger #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [prpl_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ms[31:0], pin_level[32], entry_index[38:33]
  input  wire logic [prpl_pkg::IN_W-1:0]   s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // status[1:0], slot_index[8:2], slot_count[24:9], slot_time[56:25]
  output logic [prpl_pkg::OUT_W-1:0]       m_axis_tdata
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int SW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = (SW > prpl_pkg::SLOT_W) ? SW : prpl_pkg::SLOT_W;
  localparam logic [SW-1:0] WS_END = SW'(MAX_ENTRIES);

  // config
  logic [prpl_pkg::CFG_W-1:0] period_ms;
  logic [prpl_pkg::CFG_W-1:0] min_gap_ms;

  // state
  logic                         prev_level, prev_level_next;
  logic [31:0]                  last_fall, last_fall_next;
  logic [31:0]                  period_start, period_start_next;
  logic [SW-1:0]                write_slot, write_slot_next;
  prpl_pkg::status_t            status, status_next;
  logic [MAX_ENTRIES-1:0]       slot_valid, slot_valid_next;

  // execute stage
  logic                         ex_valid;
  prpl_pkg::req_type_t          ex_req;
  logic [31:0]                  ex_now;
  logic                         ex_pin;
  logic [prpl_pkg::IDX_W-1:0]   ex_idx;
  logic                         ex_fire;
  logic                         s_fire;

  // output register
  prpl_pkg::status_t            out_status, out_status_next;
  logic [RW-1:0]                out_slot, out_slot_next;
  prpl_pkg::slot_entry_t        out_entry, out_entry_next;

  // memory
  logic [AW-1:0]                rd_addr;
  prpl_pkg::slot_entry_t        rd_entry;
  logic                         wr_en;
  prpl_pkg::slot_entry_t        wr_data;

  // sample datapath
  logic                         cur_v;
  prpl_pkg::slot_entry_t        cur;
  logic                         open_first;
  logic [32:0]                  end_sum;
  logic                         period_end;
  logic [31:0]                  gap;
  logic [17:0]                  timeout_lim;
  logic                         timed_out;
  logic                         advance;
  logic [SW-1:0]                ws1;
  logic                         ws1_in;
  logic                         full;
  logic                         falling;
  logic                         take;
  logic                         opened;
  prpl_pkg::slot_entry_t        base;
  prpl_pkg::slot_entry_t        upd;
  logic                         idx_in;
  logic                         idx_v;

  assign ex_fire       = ex_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !ex_valid || ex_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms  <= prpl_pkg::PERIOD_RESET;
      min_gap_ms <= prpl_pkg::MIN_GAP_RESET;
    end else if (cfg_we) begin
      case (prpl_pkg::cfg_index_t'(cfg_index))
        prpl_pkg::CFG_PERIOD:  period_ms  <= cfg_wdata;
        prpl_pkg::CFG_MIN_GAP: min_gap_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cur_v       = (write_slot < WS_END) && slot_valid[write_slot[AW-1:0]];
  assign cur         = cur_v ? rd_entry : '0;
  assign open_first  = (period_start == 32'd0);
  assign end_sum     = {1'b0, period_start} + 33'(period_ms);
  assign period_end  = !open_first && (end_sum < {1'b0, ex_now});
  assign gap         = ex_now - last_fall;
  assign timeout_lim = {period_ms, 2'b00};
  assign timed_out   = period_end && (gap > 32'(timeout_lim));
  assign advance     = period_end && !timed_out;
  assign ws1         = write_slot + SW'(advance && (cur.count != '0));
  assign ws1_in      = ws1 < WS_END;
  assign full        = !timed_out && !ws1_in;
  assign falling     = !ex_pin && prev_level;
  assign take        = !timed_out && !full && falling && (gap > 32'(min_gap_ms));
  assign opened      = (open_first || advance) && ws1_in;

  always_comb begin
    base = cur;
    if (opened) begin
      base.count = '0;
      base.stamp = ex_now;
    end
    upd = base;
    if (take && (base.count != prpl_pkg::COUNT_MAX)) begin
      upd.count = base.count + 16'd1;
    end
  end

  assign idx_in = int'(ex_idx) < MAX_ENTRIES;
  assign idx_v  = idx_in && slot_valid[AW'(ex_idx)];

  assign wr_en   = ex_fire && (ex_req == prpl_pkg::REQ_SAMPLE) && (opened || take);
  assign wr_data = upd;

  always_comb begin
    prev_level_next   = prev_level;
    last_fall_next    = last_fall;
    period_start_next = period_start;
    write_slot_next   = write_slot;
    status_next       = status;
    slot_valid_next   = slot_valid;
    out_status_next   = status;
    out_slot_next     = RW'(write_slot);
    out_entry_next    = cur;
    if (ex_fire) begin
      case (ex_req)
        prpl_pkg::REQ_SAMPLE: begin
          if (timed_out) begin
            status_next = prpl_pkg::STAT_INACTIVE;
          end else begin
            if (open_first || advance) begin
              period_start_next = ex_now;
            end
            write_slot_next = ws1;
            if (full) begin
              status_next = prpl_pkg::STAT_FULL;
            end else begin
              if (falling) begin
                last_fall_next = ex_now;
              end
              prev_level_next = ex_pin;
            end
            if (opened || take) begin
              slot_valid_next[ws1[AW-1:0]] = 1'b1;
            end
          end
          out_status_next = timed_out ? prpl_pkg::STAT_INACTIVE :
                            full      ? prpl_pkg::STAT_FULL : status;
          out_slot_next   = RW'(timed_out ? write_slot : ws1);
          out_entry_next  = (opened || take) ? upd : (ws1_in ? cur : '0);
        end
        prpl_pkg::REQ_CLEAR: begin
          status_next       = prpl_pkg::STAT_COLLECT;
          write_slot_next   = '0;
          period_start_next = '0;
          slot_valid_next   = '0;
          out_status_next   = prpl_pkg::STAT_COLLECT;
          out_slot_next     = '0;
          out_entry_next    = '0;
        end
        prpl_pkg::REQ_READ: begin
          out_slot_next  = RW'(ex_idx);
          out_entry_next = idx_v ? rd_entry : '0;
        end
        default: ;
      endcase
    end
  end

  // for a read, the requested entry; else the slot the next request sees, after this one's update
  assign rd_addr = (prpl_pkg::req_type_t'(s_axis_tuser) == prpl_pkg::REQ_READ)
                   ? AW'(s_axis_tdata[38:33]) : write_slot_next[AW-1:0];

  prpl_slot_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_fire),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (ws1[AW-1:0]),
    .wr_data (wr_data),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level    <= 1'b0;
      last_fall     <= '0;
      period_start  <= '0;
      write_slot    <= '0;
      status        <= prpl_pkg::STAT_COLLECT;
      slot_valid    <= '0;
      ex_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      prev_level   <= prev_level_next;
      last_fall    <= last_fall_next;
      period_start <= period_start_next;
      write_slot   <= write_slot_next;
      status       <= status_next;
      slot_valid   <= slot_valid_next;
      if (s_fire) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      ex_req <= prpl_pkg::req_type_t'(s_axis_tuser);
      ex_now <= s_axis_tdata[31:0];
      ex_pin <= s_axis_tdata[32];
      ex_idx <= s_axis_tdata[38:33];
    end
    if (ex_fire) begin
      out_status <= out_status_next;
      out_slot   <= out_slot_next;
      out_entry  <= out_entry_next;
    end
  end

  assign m_axis_tdata = {7'd0, out_entry.stamp, out_entry.count,
                         out_slot[prpl_pkg::SLOT_W-1:0], out_status};

endmodule

`default_nettype wire

### hdl/prpl_slot_store.sv
// ----------------------------------------------------------------------------
// prpl_slot_store
// Slot table memory with registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module prpl_slot_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire prpl_pkg::slot_entry_t wr_data,
  output prpl_pkg::slot_entry_t      rd_data
);

  prpl_pkg::slot_entry_t mem [DEPTH];
  prpl_pkg::slot_entry_t rd_q;
  prpl_pkg::slot_entry_t byp_q;
  logic                  byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      byp_q <= wr_data;
    end
  end

  // same-edge write to the entry being read wins over the old contents
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (rd_en) begin
      byp_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit ? byp_q : rd_q;

endmodule

`default_nettype wire

### tb/prpl_checker.sv
// ----------------------------------------------------------------------------
// prpl_checker
// Watches the request and result channels of the pulse rate period logger.
// Every accepted request runs through a cycle-free model of the pulse
// counter and its slot table; each accepted result is compared field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module prpl_checker
  import prpl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  // now_ms[31:0], pin_level[32], entry_index[38:33]
  input  wire logic [IN_W-1:0]     s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]          s_axis_tuser,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // status[1:0], slot_index[8:2], slot_count[24:9], slot_time[56:25]
  input  wire logic [OUT_W-1:0]    m_axis_tdata,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_DEPTH = 64;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } logger_result_t;

  logic [CFG_W-1:0]   period_cfg;
  logic [CFG_W-1:0]   min_gap_cfg;
  logic               prev_pin;
  logic [TIME_W-1:0]  last_fall;
  logic [TIME_W-1:0]  period_start;
  logic [SLOT_W-1:0]  wr_slot;
  status_t            status_q;
  logic [COUNT_W-1:0] slot_counts [LOG_DEPTH];
  logic [TIME_W-1:0]  slot_stamps [LOG_DEPTH];
  logic               slot_valid  [LOG_DEPTH];

  logger_result_t expected_q[$];
  int             mismatches;

  function logic [COUNT_W-1:0] count_of(input logic [SLOT_W-1:0] s);
    if (s < LOG_DEPTH && slot_valid[s[5:0]]) return slot_counts[s[5:0]];
    return '0;
  endfunction

  function logic [TIME_W-1:0] stamp_of(input logic [SLOT_W-1:0] s);
    if (s < LOG_DEPTH && slot_valid[s[5:0]]) return slot_stamps[s[5:0]];
    return '0;
  endfunction

  task open_slot(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] t);
    if (s < LOG_DEPTH) begin
      slot_counts[s[5:0]] = '0;
      slot_stamps[s[5:0]] = t;
      slot_valid[s[5:0]]  = 1'b1;
    end
  endtask

  task take_sample(input logic [TIME_W-1:0] now, input logic pin);
    logic [TIME_W:0]    period_end;
    logic [TIME_W-1:0]  gap;
    logic [COUNT_W-1:0] c;
    if (period_start == '0) begin
      period_start = now;
      open_slot(wr_slot, now);
    end
    period_end = {1'b0, period_start} + {17'b0, period_cfg};
    if (period_end < {1'b0, now}) begin
      // no fall for four periods
      if (TIME_W'(now - last_fall) > {14'b0, period_cfg, 2'b00}) begin
        status_q = STAT_INACTIVE;
        return;
      end
      if (count_of(wr_slot) != '0) wr_slot = wr_slot + 1'b1;
      open_slot(wr_slot, now);
      period_start = now;
    end
    if (wr_slot >= LOG_DEPTH) begin
      status_q = STAT_FULL;
      return;
    end
    if (pin != prev_pin && pin == 1'b0) begin
      gap = now - last_fall;
      last_fall = now;
      if (gap > {16'b0, min_gap_cfg}) begin
        c = count_of(wr_slot);
        if (!slot_valid[wr_slot[5:0]]) begin
          slot_stamps[wr_slot[5:0]] = '0;
          slot_valid[wr_slot[5:0]]  = 1'b1;
        end
        slot_counts[wr_slot[5:0]] = (c != COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
      end
    end
    prev_pin = pin;
  endtask

  always @(posedge clk) begin
    req_type_t          req;
    logic [SLOT_W-1:0]  rep;
    logger_result_t     want;
    logger_result_t     got;
    if (rst) begin
      period_cfg   = PERIOD_RESET;
      min_gap_cfg  = MIN_GAP_RESET;
      prev_pin     = 1'b0;
      last_fall    = '0;
      period_start = '0;
      wr_slot      = '0;
      status_q     = STAT_COLLECT;
      for (int i = 0; i < LOG_DEPTH; i++) slot_valid[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD:  period_cfg  = cfg_wdata;
          CFG_MIN_GAP: min_gap_cfg = cfg_wdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req = req_type_t'(s_axis_tuser);
        rep = wr_slot;
        case (req)
          REQ_SAMPLE: begin
            take_sample(s_axis_tdata[31:0], s_axis_tdata[32]);
            rep = wr_slot;
          end
          REQ_CLEAR: begin
            status_q     = STAT_COLLECT;
            wr_slot      = '0;
            period_start = '0;
            for (int i = 0; i < LOG_DEPTH; i++) slot_valid[i] = 1'b0;
            rep = '0;
          end
          REQ_READ: rep = {1'b0, s_axis_tdata[38:33]};
          default: ;
        endcase
        want.status = status_q;
        want.slot   = rep;
        want.count  = count_of(rep);
        want.stamp  = stamp_of(rep);
        expected_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.slot   = m_axis_tdata[8:2];
        got.count  = m_axis_tdata[24:9];
        got.stamp  = m_axis_tdata[56:25];
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d slot %0d count %0d time %0h",
                     got.status, got.slot, got.count, got.stamp);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.count !== want.count || got.stamp !== want.stamp) begin
            if (mismatches < 10) begin
              $display("mismatch: expected status %0d slot %0d count %0d time %0h",
                       want.status, want.slot, want.count, want.stamp);
              $display("          got      status %0d slot %0d count %0d time %0h",
                       got.status, got.slot, got.count, got.stamp);
            end
            mismatches++;
          end
        end
      end
    end
    pending    <= expected_q.size();
    fail_count <= mismatches;
  end

  initial mismatches = 0;

endmodule

### tb/pulse_rate_period_logger_tb.sv
// ----------------------------------------------------------------------------
// pulse_rate_period_logger_tb
// Drives sample, clear, read and unused requests into the pulse rate period
// logger under bursty input and a stalling result sink: a directed opening
// and random pin traffic at several period and debounce settings.
// A checker predicts every result.
// ----------------------------------------------------------------------------
module pulse_rate_period_logger_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prpl_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  int                fail_count;
  int                pending;

  logic [31:0] now_t;
  logic        pin_t;
  int          burst_left;
  int          results_taken;
  int          idle_cycles;

  always #5 clk = ~clk;

  pulse_rate_period_logger u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  prpl_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
      results_taken = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) results_taken++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result sink: a changing stall pattern, with one long hold-off after 400 results
  initial begin
    bit held;
    int mode;
    held = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!held && results_taken >= 400) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      repeat (64) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send(input req_type_t req, input logic [31:0] t, input logic pin,
                      input logic [5:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, idx, pin, t};
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic sample(input logic [31:0] t, input logic pin);
    send(REQ_SAMPLE, t, pin, 6'($urandom_range(0, 63)));
  endtask

  task automatic request(input req_type_t req, input logic [5:0] idx);
    send(req, $urandom, 1'($urandom_range(0, 1)), idx);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] gap);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_index <= CFG_MIN_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    request(REQ_CLEAR, 6'($urandom_range(0, 63)));
  endtask

  task automatic pin_traffic(input int n, input int step_max, input int toggle_pct,
                             input int jump_pct, input int clear_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct) begin
        request(REQ_CLEAR, 6'($urandom_range(0, 63)));
      end else if (r < clear_pct + 8) begin
        request(REQ_READ, 6'($urandom_range(0, 63)));
      end else if (r < clear_pct + 10) begin
        request(REQ_NONE, 6'($urandom_range(0, 63)));
      end else begin
        if ($urandom_range(0, 99) < jump_pct) now_t += $urandom;
        else now_t += $urandom_range(1, step_max);
        if ($urandom_range(0, 99) < toggle_pct) pin_t = ~pin_t;
        sample(now_t, pin_t);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PERIOD;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_SAMPLE;
    now_t         = '0;
    pin_t         = 1'b0;
    burst_left    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: period start, debounce, slot advance and reuse, timeout
    sample(32'd0, 1'b0);
    sample(32'd5, 1'b1);
    sample(32'd200, 1'b0);
    sample(32'd250, 1'b1);
    sample(32'd260, 1'b0);
    request(REQ_READ, 6'd0);
    request(REQ_READ, 6'd63);
    request(REQ_NONE, 6'd0);
    sample(32'd1100, 1'b1);
    sample(32'd1200, 1'b0);
    sample(32'd2400, 1'b1);
    sample(32'd3500, 1'b1);
    request(REQ_READ, 6'd2);
    sample(32'hFFFF_FFFF, 1'b0);
    sample(32'hFFFF_FFFF, 1'b1);
    request(REQ_READ, 6'd1);
    send(REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, 6'd63);
    request(REQ_READ, 6'd0);
    // time wraps inside one period
    sample(32'hFFFF_FFF0, 1'b1);
    sample(32'hFFFF_FFFF, 1'b0);
    sample(32'd20, 1'b1);
    sample(32'd30, 1'b0);
    request(REQ_READ, 6'd0);
    send(REQ_NONE, 32'hFFFF_FFFF, 1'b1, 6'd63);

    // short periods, pin toggling on most samples: walks the whole table until full
    now_t = 32'd1000;
    set_config(16'd2, 16'd0);
    pin_traffic(350, 1, 97, 0, 0);
    request(REQ_READ, 6'd63);

    set_config(16'd1, 16'd0);
    pin_traffic(150, 3, 50, 2, 3);

    set_config(16'hFFFF, 16'hFFFF);
    pin_traffic(100, 40000, 50, 5, 3);

    now_t = 32'hFFFF_F000;
    set_config(16'd100, 16'd50);
    pin_traffic(150, 80, 60, 3, 2);

    set_config(16'd5000, 16'd10);
    pin_traffic(150, 2000, 50, 3, 2);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
